[sv/hsl_to_rgb_unit_defines.svh]
`ifndef HSL_TO_RGB_UNIT_DEFINES_SVH
`define HSL_TO_RGB_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define H2R_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define H2R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/h2r_pkg.sv]
package h2r_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 9;
  localparam int unsigned ProdW   = 16;
  localparam int unsigned ChromaW = 9;
  localparam int unsigned WeightW = 14;
  localparam int unsigned OffW    = 6;
  localparam int unsigned R120W   = 7;
  localparam int unsigned CwW     = ChromaW + WeightW;
  localparam int unsigned MW      = 10;
  localparam int unsigned SumW    = 11;

  localparam int unsigned FracOne = 10000;

  // floor(p / 254) == (p * ChromaRecip) >> ChromaShift for every p below 2^16
  localparam int unsigned      ChromaShift = 24;
  localparam logic [16:0]      ChromaRecip = 17'd66053;
  localparam int unsigned      ChromaMulW  = ProdW + 17;

  // floor(v / 10000) == (v * XRecip) >> XShift for every v up to 256 * 10000
  localparam int unsigned      XShift  = 37;
  localparam logic [23:0]      XRecip  = 24'd13743896;
  localparam int unsigned      XMulW   = CwW + 24;

  typedef enum logic [2:0] {
    SextRed,
    SextYellow,
    SextGreen,
    SextCyan,
    SextBlue,
    SextMagenta
  } sextant_e;

  typedef struct packed {
    sextant_e              sextant;
    logic [WeightW-1:0]    weight;
  } hue_info_t;

  typedef logic [WeightW-1:0] weight_tab_t [64];

  // weight = FracOne - floor(off * FracOne / 60), off being |hue mod 120 - 60|
  function automatic weight_tab_t build_weights();
    weight_tab_t tab;
    for (int i = 0; i < 64; i++) begin
      if (i <= 60) begin
        tab[i] = WeightW'(FracOne - (i * FracOne) / 60);
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

  localparam weight_tab_t WeightTable = build_weights();

endpackage

[sv/h2r_hue_split.sv]
module h2r_hue_split
  import h2r_pkg::*;
(
  input  logic [HueW-1:0] hue_i,
  output hue_info_t       info_o
);

  logic [HueW-1:0]  base;
  logic [HueW-1:0]  diff;
  logic [R120W-1:0] r120;
  logic [OffW-1:0]  off;
  sextant_e         sext;

  always_comb begin
    if (hue_i >= HueW'(480)) begin
      base = HueW'(480);
    end else if (hue_i >= HueW'(360)) begin
      base = HueW'(360);
    end else if (hue_i >= HueW'(240)) begin
      base = HueW'(240);
    end else if (hue_i >= HueW'(120)) begin
      base = HueW'(120);
    end else begin
      base = '0;
    end
    diff = hue_i - base;
    r120 = diff[R120W-1:0];

    if (r120 >= R120W'(60)) begin
      off = OffW'(r120 - R120W'(60));
    end else begin
      off = OffW'(R120W'(60) - r120);
    end

    if (hue_i >= HueW'(300)) begin
      sext = SextMagenta;
    end else if (hue_i >= HueW'(240)) begin
      sext = SextBlue;
    end else if (hue_i >= HueW'(180)) begin
      sext = SextCyan;
    end else if (hue_i >= HueW'(120)) begin
      sext = SextGreen;
    end else if (hue_i >= HueW'(60)) begin
      sext = SextYellow;
    end else begin
      sext = SextRed;
    end
  end

  assign info_o.sextant = sext;
  assign info_o.weight  = WeightTable[off];

endmodule

[sv/hsl_to_rgb_unit.sv]
// Channel   Dir  Handshake               Payload
// input     in   in_valid_i/in_ready_o   hue_deg_i, sat_level_i, lum_level_i
// output    out  out_valid_o/out_ready_i red_out_o, green_out_o, blue_out_o
//
// Five register stages; one pixel enters per clock while the output is not stalled.
// The two reciprocal multipliers are each closed by a register.
// Reset clears the stage valid bits only; the datapath needs no reset.
// A stall at the output freezes every stage at once; nothing is dropped.
`include "hsl_to_rgb_unit_defines.svh"

module hsl_to_rgb_unit
  import h2r_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [HueW-1:0]  hue_deg_i,
  input  logic [ChanW-1:0] sat_level_i,
  input  logic [ChanW-1:0] lum_level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] red_out_o,
  output logic [ChanW-1:0] green_out_o,
  output logic [ChanW-1:0] blue_out_o
);

  function automatic logic [ChanW-1:0] clamp_chan(logic signed [SumW-1:0] v);
    logic [ChanW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > SumW'(255)) begin
      r = '1;
    end else begin
      r = v[ChanW-1:0];
    end
    return r;
  endfunction

  logic adv;

  // stage 1
  hue_info_t         hinfo;
  logic [ChanW:0]    twice;
  logic [ChanW:0]    lum_dev;
  logic [ChanW-1:0]  span;
  logic [ProdW-1:0]  prod_d;
  logic              v1_q;
  logic [ProdW-1:0]  prod_q;
  hue_info_t         h1_q;
  logic [ChanW-1:0]  lum1_q;

  // stage 2
  logic [ChromaMulW-1:0] chroma_full;
  logic                  v2_q;
  logic [ChromaW-1:0]    chroma2_q;
  hue_info_t             h2_q;
  logic [ChanW-1:0]      lum2_q;

  // stage 3
  logic                  v3_q;
  logic [CwW-1:0]        cw_q;
  logic [ChromaW-1:0]    chroma3_q;
  logic signed [MW-1:0]  m_d;
  logic signed [MW-1:0]  m3_q;
  sextant_e              s3_q;

  // stage 4
  logic [XMulW-1:0]      x_full;
  logic                  v4_q;
  logic [ChromaW-1:0]    xval4_q;
  logic [ChromaW-1:0]    chroma4_q;
  logic signed [MW-1:0]  m4_q;
  sextant_e              s4_q;

  // stage 5
  logic signed [SumW-1:0] c_sum;
  logic signed [SumW-1:0] x_sum;
  logic signed [SumW-1:0] m_sum;
  logic [ChanW-1:0]       c_ch;
  logic [ChanW-1:0]       x_ch;
  logic [ChanW-1:0]       m_ch;
  logic [ChanW-1:0]       red_d;
  logic [ChanW-1:0]       green_d;
  logic [ChanW-1:0]       blue_d;
  logic                   v5_q;
  logic [ChanW-1:0]       red_q;
  logic [ChanW-1:0]       green_q;
  logic [ChanW-1:0]       blue_q;

  assign adv        = !v5_q || out_ready_i;
  assign in_ready_o = adv;

  h2r_hue_split u_hue_split (
    .hue_i  (hue_deg_i),
    .info_o (hinfo)
  );

  always_comb begin
    twice = {lum_level_i, 1'b0};
    if (twice >= (ChanW+1)'(255)) begin
      lum_dev = twice - (ChanW+1)'(255);
    end else begin
      lum_dev = (ChanW+1)'(255) - twice;
    end
    span   = ChanW'((ChanW+1)'(255) - lum_dev);
    prod_d = ProdW'(span) * ProdW'(sat_level_i);
  end

  assign chroma_full = ChromaMulW'(prod_q) * ChromaMulW'(ChromaRecip);
  assign m_d = $signed(MW'(lum2_q)) - $signed(MW'(chroma2_q >> 1));
  assign x_full = XMulW'(cw_q) * XMulW'(XRecip);

  always_comb begin
    c_sum = $signed(SumW'(chroma4_q)) + SumW'(m4_q);
    x_sum = $signed(SumW'(xval4_q)) + SumW'(m4_q);
    m_sum = SumW'(m4_q);
    c_ch  = clamp_chan(c_sum);
    x_ch  = clamp_chan(x_sum);
    m_ch  = clamp_chan(m_sum);
    case (s4_q)
      SextRed:     begin red_d = c_ch; green_d = x_ch; blue_d = m_ch; end
      SextYellow:  begin red_d = x_ch; green_d = c_ch; blue_d = m_ch; end
      SextGreen:   begin red_d = m_ch; green_d = c_ch; blue_d = x_ch; end
      SextCyan:    begin red_d = m_ch; green_d = x_ch; blue_d = c_ch; end
      SextBlue:    begin red_d = x_ch; green_d = m_ch; blue_d = c_ch; end
      SextMagenta: begin red_d = c_ch; green_d = m_ch; blue_d = x_ch; end
      default:     begin red_d = c_ch; green_d = m_ch; blue_d = x_ch; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q    <= prod_d;
      h1_q      <= hinfo;
      lum1_q    <= lum_level_i;

      chroma2_q <= chroma_full[ChromaShift +: ChromaW];
      h2_q      <= h1_q;
      lum2_q    <= lum1_q;

      cw_q      <= CwW'(chroma2_q) * CwW'(h2_q.weight);
      chroma3_q <= chroma2_q;
      m3_q      <= m_d;
      s3_q      <= h2_q.sextant;

      xval4_q   <= x_full[XShift +: ChromaW];
      chroma4_q <= chroma3_q;
      m4_q      <= m3_q;
      s4_q      <= s3_q;

      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
    end
  end

  assign out_valid_o = v5_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

  `H2R_ASSERT_NOW(a_chroma_range, clk_i, rst_ni, v2_q,
                  chroma2_q <= ChromaW'(256), "chroma above 256")
  `H2R_ASSERT_NOW(a_weight_range, clk_i, rst_ni, v2_q,
                  h2_q.weight <= WeightW'(FracOne), "hue weight above one")
  `H2R_ASSERT_NOW(a_x_le_chroma, clk_i, rst_ni, v4_q,
                  xval4_q <= chroma4_q, "X exceeds chroma")
  `H2R_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !adv,
                   $stable({v1_q, v2_q, v3_q, v4_q}), "pipeline moved while stalled")

endmodule
